FILE: rtl/ght_pkg.sv
// Shared constants, codes and control types for the generational handle table.
package ght_pkg;

    localparam int ENTRIES      = 4096;
    localparam int GEN_BITS     = 15;
    localparam int PAYLOAD_BITS = 32;

    localparam int CMD_W    = 2;
    localparam int TAG_W    = 5;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

    typedef struct packed {
        logic capture;
        logic commit;
    } ght_ctrl_t;

endpackage

FILE: rtl/ght_req_if.sv
// Request channel: command word with handle, payload and type tag.
interface ght_req_if #(
    parameter int IDX_W = $clog2(ght_pkg::ENTRIES),
    parameter int GEN_W = ght_pkg::GEN_BITS,
    parameter int PAY_W = ght_pkg::PAYLOAD_BITS
);
    logic                         valid;
    logic                         ready;
    logic [ght_pkg::CMD_W-1:0]    cmd;
    logic [IDX_W-1:0]             slot_index;
    logic [GEN_W-1:0]             generation;
    logic [PAY_W-1:0]             payload;
    logic [ght_pkg::TAG_W-1:0]    type_tag;

    modport source (output valid, cmd, slot_index, generation, payload, type_tag,
                    input ready);
    modport sink   (input valid, cmd, slot_index, generation, payload, type_tag,
                    output ready);
    modport mon    (input valid, ready, cmd, slot_index, generation, payload, type_tag);
endinterface

FILE: rtl/ght_rsp_if.sv
// Response channel: status word with handle, payload, tag and active count.
interface ght_rsp_if #(
    parameter int IDX_W = $clog2(ght_pkg::ENTRIES),
    parameter int GEN_W = ght_pkg::GEN_BITS,
    parameter int PAY_W = ght_pkg::PAYLOAD_BITS
);
    logic                          valid;
    logic                          ready;
    logic [ght_pkg::STATUS_W-1:0]  status;
    logic [IDX_W-1:0]              out_index;
    logic [GEN_W-1:0]              out_generation;
    logic [PAY_W-1:0]              out_payload;
    logic [ght_pkg::TAG_W-1:0]     out_type_tag;
    logic [IDX_W-1:0]              active_count;

    modport source (output valid, status, out_index, out_generation, out_payload,
                    out_type_tag, active_count, input ready);
    modport sink   (input valid, status, out_index, out_generation, out_payload,
                    out_type_tag, active_count, output ready);
    modport mon    (input valid, ready, status, out_index, out_generation, out_payload,
                    out_type_tag, active_count);
endinterface

FILE: rtl/ght_ctrl.sv
// Sequencing state machine: request capture, commit and output register valid.
module ght_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output ght_pkg::ght_ctrl_t ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = ctrl.commit | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/ght_dp.sv
// Slot tables, free-list head, counters and response register.
module ght_dp #(
    parameter int ENTRIES      = ght_pkg::ENTRIES,
    parameter int GEN_BITS     = ght_pkg::GEN_BITS,
    parameter int PAYLOAD_BITS = ght_pkg::PAYLOAD_BITS,
    parameter int IDX_W        = $clog2(ENTRIES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ght_pkg::ght_ctrl_t            ctrl,
    input  logic [ght_pkg::CMD_W-1:0]     cmd,
    input  logic [IDX_W-1:0]              slot_index,
    input  logic [GEN_BITS-1:0]           generation,
    input  logic [PAYLOAD_BITS-1:0]       payload,
    input  logic [ght_pkg::TAG_W-1:0]     type_tag,
    output logic [ght_pkg::STATUS_W-1:0]  status,
    output logic [IDX_W-1:0]              out_index,
    output logic [GEN_BITS-1:0]           out_generation,
    output logic [PAYLOAD_BITS-1:0]       out_payload,
    output logic [ght_pkg::TAG_W-1:0]     out_type_tag,
    output logic [IDX_W-1:0]              active_count
);

    // entry word: {next free link, generation, active}
    localparam int META_W = IDX_W + GEN_BITS + 1;
    localparam logic [IDX_W-1:0]    LAST_SLOT = IDX_W'(ENTRIES - 1);
    localparam logic [GEN_BITS-1:0] GEN_ONE   = GEN_BITS'(1);

    logic [META_W-1:0]       meta_mem [ENTRIES];
    logic [PAYLOAD_BITS-1:0] pay_mem  [ENTRIES];

    // control state
    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [IDX_W-1:0] live_reg, live_next;
    logic [IDX_W-1:0] fill_reg, fill_next;

    // captured request and read data
    logic [ght_pkg::CMD_W-1:0] cmd_reg;
    logic [IDX_W-1:0]          addr_reg;
    logic [GEN_BITS-1:0]       gen_in_reg;
    logic [PAYLOAD_BITS-1:0]   pay_reg;
    logic [ght_pkg::TAG_W-1:0] tag_reg;
    logic                      range_ok_reg;
    logic [META_W-1:0]         meta_rd_reg;
    logic [PAYLOAD_BITS-1:0]   pay_rd_reg;

    // response register
    logic [ght_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]             oidx_reg, oidx_next;
    logic [GEN_BITS-1:0]          ogen_reg, ogen_next;
    logic [PAYLOAD_BITS-1:0]      opay_reg, opay_next;
    logic [ght_pkg::TAG_W-1:0]    otag_reg, otag_next;

    logic [IDX_W-1:0]    rd_addr;
    logic                fresh;
    logic [IDX_W-1:0]    cur_link;
    logic [GEN_BITS-1:0] cur_gen;
    logic                cur_act;
    logic [GEN_BITS-1:0] gen_inc;
    logic [GEN_BITS-1:0] gen_new;
    logic                full;
    logic                hit;
    logic                meta_wr;
    logic                pay_wr;
    logic [META_W-1:0]   meta_wdata;

    assign rd_addr = (cmd == ght_pkg::CMD_ADD) ? free_head_reg : slot_index;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg      <= cmd;
            addr_reg     <= rd_addr;
            gen_in_reg   <= generation;
            pay_reg      <= payload;
            tag_reg      <= type_tag;
            range_ok_reg <= ({1'b0, slot_index} < (IDX_W + 1)'(ENTRIES));
            meta_rd_reg  <= meta_mem[rd_addr];
            pay_rd_reg   <= pay_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit && meta_wr)
        begin
            meta_mem[addr_reg] <= meta_wdata;
        end
        if (ctrl.commit && pay_wr)
        begin
            pay_mem[addr_reg] <= pay_reg;
        end
    end

    // entries at or above the fill mark were never touched and read as reset
    always_comb
    begin
        fresh    = (addr_reg >= fill_reg);
        cur_link = fresh ? (addr_reg + IDX_W'(1)) : meta_rd_reg[META_W-1 -: IDX_W];
        cur_gen  = fresh ? GEN_ONE : meta_rd_reg[GEN_BITS:1];
        cur_act  = fresh ? 1'b0 : meta_rd_reg[0];
        gen_inc  = cur_gen + GEN_ONE;
        gen_new  = (gen_inc == '0) ? GEN_ONE : gen_inc;
        full     = (live_reg >= LAST_SLOT) || (free_head_reg >= LAST_SLOT);
        hit      = range_ok_reg && cur_act && (cur_gen == gen_in_reg);
    end

    always_comb
    begin
        free_head_next = free_head_reg;
        live_next      = live_reg;
        fill_next      = fill_reg;
        meta_wr        = 1'b0;
        pay_wr         = 1'b0;
        meta_wdata     = {free_head_reg, cur_gen, 1'b0};
        status_next    = ght_pkg::ST_OK;
        oidx_next      = addr_reg;
        ogen_next      = '0;
        opay_next      = '0;
        otag_next      = '0;
        case (cmd_reg)
            ght_pkg::CMD_ADD:
            begin
                if (full)
                begin
                    status_next = ght_pkg::ST_FULL;
                    oidx_next   = '0;
                end
                else
                begin
                    // pop head, advance generation, mark active
                    meta_wr        = 1'b1;
                    meta_wdata     = {{IDX_W{1'b0}}, gen_new, 1'b1};
                    pay_wr         = 1'b1;
                    free_head_next = cur_link;
                    live_next      = live_reg + IDX_W'(1);
                    if (addr_reg == fill_reg)
                    begin
                        fill_next = fill_reg + IDX_W'(1);
                    end
                    ogen_next = gen_new;
                    otag_next = tag_reg;
                end
            end
            default:
            begin
                if (!hit)
                begin
                    status_next = ght_pkg::ST_STALE;
                end
                else
                begin
                    case (cmd_reg)
                        ght_pkg::CMD_UPDATE:
                        begin
                            pay_wr = 1'b1;
                        end
                        ght_pkg::CMD_REMOVE:
                        begin
                            // push slot back on the free list
                            meta_wr        = 1'b1;
                            meta_wdata     = {free_head_reg, cur_gen, 1'b0};
                            free_head_next = addr_reg;
                            live_next      = live_reg - IDX_W'(1);
                        end
                        default:
                        begin
                            opay_next = pay_rd_reg;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            live_reg      <= '0;
            fill_reg      <= '0;
        end
        else if (ctrl.commit)
        begin
            free_head_reg <= free_head_next;
            live_reg      <= live_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            status_reg <= status_next;
            oidx_reg   <= oidx_next;
            ogen_reg   <= ogen_next;
            opay_reg   <= opay_next;
            otag_reg   <= otag_next;
        end
    end

    assign status         = status_reg;
    assign out_index      = oidx_reg;
    assign out_generation = ogen_reg;
    assign out_payload    = opay_reg;
    assign out_type_tag   = otag_reg;
    assign active_count   = live_reg;

endmodule

FILE: rtl/generational_handle_table.sv
// Top level of the generational handle table.
// An accepted request word is captured with its slot table read, then committed by
// a read-modify-write into the response register, held back while that register is
// still held by a stalled sink. No new request word is taken until the last one commits.
// Reset: asynchronous active low; clears free-list head, active count and fill mark.
// Untouched slots read as reset values through the fill mark, so no clearing pass.
module generational_handle_table #(
    parameter int ENTRIES      = ght_pkg::ENTRIES,
    parameter int GEN_BITS     = ght_pkg::GEN_BITS,
    parameter int PAYLOAD_BITS = ght_pkg::PAYLOAD_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    ght_req_if.sink    req,
    ght_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(ENTRIES);

    ght_pkg::ght_ctrl_t ctrl;

    ght_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    ght_dp #(
        .ENTRIES      (ENTRIES),
        .GEN_BITS     (GEN_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .IDX_W        (IDX_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cmd            (req.cmd),
        .slot_index     (req.slot_index),
        .generation     (req.generation),
        .payload        (req.payload),
        .type_tag       (req.type_tag),
        .status         (rsp.status),
        .out_index      (rsp.out_index),
        .out_generation (rsp.out_generation),
        .out_payload    (rsp.out_payload),
        .out_type_tag   (rsp.out_type_tag),
        .active_count   (rsp.active_count)
    );

endmodule

FILE: rtl/ght_checker.sv
// Port-level assertions for the generational handle table, with its bind.
module ght_checker #(
    parameter int ENTRIES = ght_pkg::ENTRIES
) (
    input logic       clk,
    input logic       rst_n,
    ght_req_if.sink   req,
    ght_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(ENTRIES);

    a_one_word_per_two: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted on consecutive cycles");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ght_pkg::ST_FULL |->
            rsp.active_count == CNT_W'(ENTRIES - 1))
        else $error("full reported below capacity");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ght_pkg::ST_OK |->
            rsp.out_generation == '0 && rsp.out_payload == '0 && rsp.out_type_tag == '0)
        else $error("error response carries handle data");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=>
            rsp.valid && $stable(rsp.status) && $stable(rsp.out_index)
            && $stable(rsp.active_count))
        else $error("stalled response word changed");

endmodule

bind generational_handle_table ght_checker #(.ENTRIES(ENTRIES)) u_ght_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);
